[sv/sso_pkg.sv]
// Package for the sphere versus segment overlap test.
// Holds region codes and the default coordinate width; used by every module but sso_mul.
`default_nettype none
package sso_pkg;
    localparam int unsigned CoordBitsDefault = 32;
    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_INTERIOR = 2'd1,
        REGION_FINISH   = 2'd2
    } t_region;
endpackage
`default_nettype wire

[sv/sphere_segment_overlap.sv]
// Sphere versus segment overlap test, top level with valid/ready and a skid buffer.
// Depends on sso_pkg, sso_front and sso_back.
// Accepts one query per cycle while o_ready is high; each query's result passes through
// nine register stages: the coordinate differences, two chained multiplier pipelines of
// three stages each, the dot-product sums and the output register. A skid buffer holds a
// result when the output is stalled, so the pipeline freezes without loss.
`default_nettype none
module sphere_segment_overlap
    import sso_pkg::*;
#(
    parameter int unsigned COORD_BITS = CoordBitsDefault
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_center_x,
    input  wire logic signed [COORD_BITS-1:0] i_center_y,
    input  wire logic signed [COORD_BITS-1:0] i_center_z,
    input  wire logic [COORD_BITS-2:0]        i_sphere_radius,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_start_z,
    input  wire logic signed [COORD_BITS-1:0] i_finish_x,
    input  wire logic signed [COORD_BITS-1:0] i_finish_y,
    input  wire logic signed [COORD_BITS-1:0] i_finish_z,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_hit,
    output logic [1:0]                        o_nearest_region
);
    localparam int unsigned LAT = 9;
    localparam int unsigned SW = 2 * COORD_BITS + 4;

    logic [LAT-1:0] r_vld;
    logic           w_en;
    logic           r_sk_vld, r_sk_hit;
    t_region        r_sk_region;
    logic           w_hit;
    t_region        w_region;
    logic signed [SW-1:0] w_vw, w_vv, w_ww, w_ee, w_rr;
    logic signed [COORD_BITS-1:0] w_c [3], w_s [3], w_f [3];

    // Pipeline advances unless the skid slot is full and the last stage holds data.
    assign w_en    = !r_sk_vld || !r_vld[LAT-1];
    assign o_ready = w_en;

    assign w_c = '{i_center_x, i_center_y, i_center_z};
    assign w_s = '{i_start_x, i_start_y, i_start_z};
    assign w_f = '{i_finish_x, i_finish_y, i_finish_z};

    sso_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk, .i_en(w_en), .i_c(w_c), .i_s(w_s), .i_f(w_f), .i_r(i_sphere_radius),
        .o_vw(w_vw), .o_vv(w_vv), .o_ww(w_ww), .o_ee(w_ee), .o_rr(w_rr)
    );
    sso_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk, .i_en(w_en), .i_vw(w_vw), .i_vv(w_vv), .i_ww(w_ww), .i_ee(w_ee),
        .i_rr(w_rr), .o_hit(w_hit), .o_region(w_region)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_sk_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_valid};
            end
            if (!r_sk_vld) begin
                if (w_en && r_vld[LAT-1] && !i_ready) begin
                    r_sk_vld <= 1'b1;
                end
            end else if (i_ready) begin
                r_sk_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_vld) begin
            r_sk_hit    <= w_hit;
            r_sk_region <= w_region;
        end
    end

    assign o_valid          = r_sk_vld || r_vld[LAT-1];
    assign o_hit            = r_sk_vld ? r_sk_hit : w_hit;
    assign o_nearest_region = r_sk_vld ? r_sk_region : w_region;

    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_nearest_region != 2'd3) else $error("bad region code");
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld && !i_ready |=> r_sk_vld) else $error("skid dropped");
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld)) else $error("pipeline moved while stalled");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sk_vld |-> o_ready) else $error("ready low with empty skid");
endmodule
`default_nettype wire

[sv/sso_mul.sv]
// Pipelined signed multiplier built from 32x32 partial products over three stages.
// Used by the distance stages of the overlap test; depends on nothing else.
`default_nettype none
module sso_mul #(
    parameter int unsigned AW = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [AW-1:0]  i_a,
    input  wire logic signed [AW-1:0]  i_b,
    output logic signed [2*AW-1:0]     o_p
);
    localparam int unsigned NL = (AW + 31) / 32;
    localparam int unsigned EW = NL * 32;

    logic [EW-1:0]            w_ma, w_mb;
    logic                     w_neg;
    logic [63:0]              r_pp [NL*NL];
    logic                     r_neg1, r_neg2;
    logic [2*EW-1:0]          r_acc [NL];
    logic [2*EW-1:0]          n_acc [NL];
    logic [2*EW-1:0]          r_sum, n_sum;

    always_comb begin
        w_neg = i_a[AW-1] ^ i_b[AW-1];
        w_ma  = EW'(i_a[AW-1] ? -{{(EW-AW){i_a[AW-1]}}, i_a} : {{(EW-AW){1'b0}}, i_a});
        w_mb  = EW'(i_b[AW-1] ? -{{(EW-AW){i_b[AW-1]}}, i_b} : {{(EW-AW){1'b0}}, i_b});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    r_pp[i*NL+j] <= 64'(w_ma[i*32 +: 32]) * 64'(w_mb[j*32 +: 32]);
                end
            end
            r_neg1 <= w_neg;
        end
    end

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            n_acc[i] = '0;
            for (int j = 0; j < NL; j++) begin
                n_acc[i] = n_acc[i] + ((2*EW)'(r_pp[i*NL+j]) << ((i + j) * 32));
            end
        end
        n_sum = '0;
        for (int i = 0; i < NL; i++) begin
            n_sum = n_sum + r_acc[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_neg2 <= r_neg1;
            r_sum  <= r_neg2 ? -n_sum : n_sum;
        end
    end

    assign o_p = (2*AW)'(r_sum);
endmodule
`default_nettype wire

[sv/sso_front.sv]
// Front stages: coordinate differences, then the dot products and squared radius.
// Depends on sso_pkg and sso_mul.
`default_nettype none
module sso_front
    import sso_pkg::*;
#(
    parameter int unsigned COORD_BITS = CoordBitsDefault
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [COORD_BITS-1:0] i_c [3],
    input  wire logic signed [COORD_BITS-1:0] i_s [3],
    input  wire logic signed [COORD_BITS-1:0] i_f [3],
    input  wire logic [COORD_BITS-2:0]        i_r,
    output logic signed [2*COORD_BITS+3:0]    o_vw,
    output logic signed [2*COORD_BITS+3:0]    o_vv,
    output logic signed [2*COORD_BITS+3:0]    o_ww,
    output logic signed [2*COORD_BITS+3:0]    o_ee,
    output logic signed [2*COORD_BITS+3:0]    o_rr
);
    localparam int unsigned DW = COORD_BITS + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned SW = 2 * COORD_BITS + 4;

    logic signed [DW-1:0] r_v [3], r_w [3], r_e [3];
    logic signed [DW-1:0] r_r;
    logic signed [PW-1:0] w_vw [3], w_vv [3], w_ww [3], w_ee [3], w_rr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_v[k] <= DW'(i_f[k]) - DW'(i_s[k]);
                r_w[k] <= DW'(i_c[k]) - DW'(i_s[k]);
                r_e[k] <= DW'(i_c[k]) - DW'(i_f[k]);
            end
            r_r <= DW'({2'b00, i_r});
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_dot
        sso_mul #(.AW(DW)) u_vw (.i_clk, .i_en, .i_a(r_v[k]), .i_b(r_w[k]), .o_p(w_vw[k]));
        sso_mul #(.AW(DW)) u_vv (.i_clk, .i_en, .i_a(r_v[k]), .i_b(r_v[k]), .o_p(w_vv[k]));
        sso_mul #(.AW(DW)) u_ww (.i_clk, .i_en, .i_a(r_w[k]), .i_b(r_w[k]), .o_p(w_ww[k]));
        sso_mul #(.AW(DW)) u_ee (.i_clk, .i_en, .i_a(r_e[k]), .i_b(r_e[k]), .o_p(w_ee[k]));
    end
    sso_mul #(.AW(DW)) u_rr (.i_clk, .i_en, .i_a(r_r), .i_b(r_r), .o_p(w_rr));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_vw <= SW'(w_vw[0]) + SW'(w_vw[1]) + SW'(w_vw[2]);
            o_vv <= SW'(w_vv[0]) + SW'(w_vv[1]) + SW'(w_vv[2]);
            o_ww <= SW'(w_ww[0]) + SW'(w_ww[1]) + SW'(w_ww[2]);
            o_ee <= SW'(w_ee[0]) + SW'(w_ee[1]) + SW'(w_ee[2]);
            o_rr <= SW'(w_rr);
        end
    end
endmodule
`default_nettype wire

[sv/sso_back.sv]
// Back stages: region choice and the cross-multiplied interior distance test.
// Depends on sso_pkg and sso_mul.
`default_nettype none
module sso_back
    import sso_pkg::*;
#(
    parameter int unsigned COORD_BITS = CoordBitsDefault
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic signed [2*COORD_BITS+3:0] i_vw,
    input  wire logic signed [2*COORD_BITS+3:0] i_vv,
    input  wire logic signed [2*COORD_BITS+3:0] i_ww,
    input  wire logic signed [2*COORD_BITS+3:0] i_ee,
    input  wire logic signed [2*COORD_BITS+3:0] i_rr,
    output logic                              o_hit,
    output t_region                           o_region
);
    localparam int unsigned SW = 2 * COORD_BITS + 4;
    localparam int unsigned LAT = 3;

    logic signed [2*SW-1:0] w_lhs, w_rden, w_nn;
    t_region n_region;
    logic    n_ehit;
    t_region r_region [LAT];
    logic    r_ehit [LAT];

    sso_mul #(.AW(SW)) u_lhs (.i_clk, .i_en, .i_a(i_ww), .i_b(i_vv), .o_p(w_lhs));
    sso_mul #(.AW(SW)) u_rden (.i_clk, .i_en, .i_a(i_rr), .i_b(i_vv), .o_p(w_rden));
    sso_mul #(.AW(SW)) u_nn (.i_clk, .i_en, .i_a(i_vw), .i_b(i_vw), .o_p(w_nn));

    always_comb begin
        if (i_vv == '0 || i_vw < 0) begin
            n_region = REGION_START;
            n_ehit   = i_ww < i_rr;
        end else if (i_vw > i_vv) begin
            n_region = REGION_FINISH;
            n_ehit   = i_ee < i_rr;
        end else begin
            n_region = REGION_INTERIOR;
            n_ehit   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_region[0] <= n_region;
            r_ehit[0]   <= n_ehit;
            for (int k = 1; k < LAT; k++) begin
                r_region[k] <= r_region[k-1];
                r_ehit[k]   <= r_ehit[k-1];
            end
            o_region <= r_region[LAT-1];
            o_hit    <= (r_region[LAT-1] == REGION_INTERIOR) ?
                        (w_lhs < w_rden + w_nn) : r_ehit[LAT-1];
        end
    end
endmodule
`default_nettype wire
